[design/dfr_pkg.sv]
// Shared types and constants for the sync/length/XOR deframer.
`default_nettype none

package dfr_pkg;

  // Depth of the item queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Byte and configuration widths.
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_ADDR_W = 1;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SYNC_FIRST  = 1'b0,
    CFG_SYNC_SECOND = 1'b1
  } cfg_reg_e;

  // Frame parsing phases.
  typedef enum logic [2:0] {
    PH_HUNT_FIRST  = 3'd0,
    PH_HUNT_SECOND = 3'd1,
    PH_ID          = 3'd2,
    PH_LENGTH      = 3'd3,
    PH_PAYLOAD     = 3'd4,
    PH_CHECKSUM    = 3'd5
  } phase_e;

  // One result item as it travels from the front to the output.
  typedef struct packed {
    logic [BYTE_W-1:0] frame_id;
    logic [BYTE_W-1:0] frame_length;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] byte_index;
    logic              is_end;
    logic              checksum_ok;
  } dfr_item_t;

endpackage : dfr_pkg

`default_nettype wire

[design/dfr_front.sv]
// Front part: sync hunt, header capture, payload tagging and checksum check.
`default_nettype none

module dfr_front import dfr_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [BYTE_W-1:0]     cfg_wdata_i,
  input  wire logic                  accept_i,
  input  wire logic [BYTE_W-1:0]     rx_byte_i,
  output logic                       item_valid_o,
  output dfr_item_t                  item_o
);

  logic [BYTE_W-1:0] sync_first_q;
  logic [BYTE_W-1:0] sync_second_q;
  phase_e            phase_q, phase_d;
  logic [BYTE_W-1:0] id_q, id_d;
  logic [BYTE_W-1:0] len_q, len_d;
  logic [BYTE_W-1:0] cnt_q, cnt_d;
  logic [BYTE_W-1:0] xor_q, xor_d;
  logic [BYTE_W-1:0] cnt_inc;

  // Configuration registers for the two sync byte values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= '0;
      sync_second_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_SYNC_FIRST:  sync_first_q  <= cfg_wdata_i;
        CFG_SYNC_SECOND: sync_second_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Phase register and per-frame state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT_FIRST;
      id_q    <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      xor_q   <= '0;
    end else begin
      phase_q <= phase_d;
      id_q    <= id_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      xor_q   <= xor_d;
    end
  end

  assign cnt_inc = cnt_q + BYTE_W'(1);

  // Next phase and the result item caused by the accepted beat.
  always_comb begin
    phase_d      = phase_q;
    id_d         = id_q;
    len_d        = len_q;
    cnt_d        = cnt_q;
    xor_d        = xor_q;
    item_valid_o = 1'b0;
    item_o       = '{frame_id:     id_q,
                     frame_length: len_q,
                     data_byte:    rx_byte_i,
                     byte_index:   cnt_q,
                     is_end:       1'b0,
                     checksum_ok:  1'b0};
    if (accept_i) begin
      unique case (phase_q)
        PH_HUNT_SECOND: begin
          // A byte that matches the first sync value keeps the partial match.
          if (rx_byte_i == sync_second_q) begin
            xor_d   = sync_first_q ^ sync_second_q;
            phase_d = PH_ID;
          end else if (rx_byte_i != sync_first_q) begin
            phase_d = PH_HUNT_FIRST;
          end
        end
        PH_ID: begin
          id_d    = rx_byte_i;
          xor_d   = xor_q ^ rx_byte_i;
          phase_d = PH_LENGTH;
        end
        PH_LENGTH: begin
          len_d   = rx_byte_i;
          xor_d   = xor_q ^ rx_byte_i;
          cnt_d   = '0;
          phase_d = (rx_byte_i == '0) ? PH_CHECKSUM : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          item_valid_o = 1'b1;
          xor_d        = xor_q ^ rx_byte_i;
          cnt_d        = cnt_inc;
          if (cnt_inc == len_q) begin
            phase_d = PH_CHECKSUM;
          end
        end
        PH_CHECKSUM: begin
          item_valid_o       = 1'b1;
          item_o.data_byte   = '0;
          item_o.byte_index  = '0;
          item_o.is_end      = 1'b1;
          item_o.checksum_ok = (rx_byte_i == xor_q);
          phase_d            = PH_HUNT_FIRST;
        end
        default: begin
          phase_d = (rx_byte_i == sync_first_q) ? PH_HUNT_SECOND : PH_HUNT_FIRST;
        end
      endcase
    end
  end

endmodule : dfr_front

`default_nettype wire

[design/dfr_queue.sv]
// Short item queue that decouples the front part from the output stage.
`default_nettype none

module dfr_queue import dfr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_en_i,
  input  dfr_item_t wr_item_i,
  input  wire logic rd_en_i,
  output dfr_item_t rd_item_o,
  output logic      full_o,
  output logic      empty_o
);

  dfr_item_t         entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_wr;
  logic              do_rd;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_wr   = wr_en_i && !full_o;
  assign do_rd   = rd_en_i && !empty_o;

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entries_q[wr_ptr_q] <= wr_item_i;
    end
  end

  assign rd_item_o = entries_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule : dfr_queue

`default_nettype wire

[design/dfr_back.sv]
// Back part: output register that presents the oldest item until it is popped.
`default_nettype none

module dfr_back import dfr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_empty_i,
  input  dfr_item_t q_item_i,
  output logic      q_pop_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output dfr_item_t out_o
);

  logic      out_valid_q;
  dfr_item_t out_q;

  // Refill the output register when it is free or being drained this cycle.
  assign q_pop_o = !q_empty_i && (!out_valid_q || pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= q_item_i;
    end
  end

  assign empty_o = !out_valid_q;
  assign out_o   = out_q;

endmodule : dfr_back

`default_nettype wire

[design/sync_length_xor_deframer_top.sv]
// Top level of the sync/length/XOR frame deframer.
//
//   Channel  | Direction | Handshake        | Beat contents
//   ---------+-----------+------------------+---------------------------------------
//   input    | in        | push_i / full_o  | rx_byte_i
//   result   | out       | empty_o / pop_i  | frame_id, frame_length, data_byte,
//            |           |                  | byte_index, is_end, checksum_ok
//   config   | in        | cfg_we_i         | cfg_addr_i, cfg_wdata_i
//
// One input beat is accepted every cycle while the four-entry item queue has room.
// The item for an accepted beat is written into the queue and then loaded into the output register.
// Reset clears the parser to the sync hunt and both sync values to zero.
// A stalled output fills the queue; full_o rises only once all four entries are taken.
`default_nettype none

module sync_length_xor_deframer_top import dfr_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [BYTE_W-1:0]     cfg_wdata_i,
  input  wire logic                  push_i,
  output logic                       full_o,
  input  wire logic [BYTE_W-1:0]     rx_byte_i,
  output logic                       empty_o,
  input  wire logic                  pop_i,
  output logic [BYTE_W-1:0]          frame_id_o,
  output logic [BYTE_W-1:0]          frame_length_o,
  output logic [BYTE_W-1:0]          data_byte_o,
  output logic [BYTE_W-1:0]          byte_index_o,
  output logic                       is_end_o,
  output logic                       checksum_ok_o
);

  logic      accept;
  logic      item_valid;
  dfr_item_t item;
  dfr_item_t q_item;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;
  dfr_item_t out_item;

  assign full_o = q_full;
  assign accept = push_i && !q_full;

  dfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .rx_byte_i    (rx_byte_i),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  dfr_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (item_valid),
    .wr_item_i (item),
    .rd_en_i   (q_pop),
    .rd_item_o (q_item),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  dfr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .pop_i     (pop_i),
    .empty_o   (empty_o),
    .out_o     (out_item)
  );

  // Result fields.
  assign frame_id_o     = out_item.frame_id;
  assign frame_length_o = out_item.frame_length;
  assign data_byte_o    = out_item.data_byte;
  assign byte_index_o   = out_item.byte_index;
  assign is_end_o       = out_item.is_end;
  assign checksum_ok_o  = out_item.checksum_ok;

endmodule : sync_length_xor_deframer_top

`default_nettype wire

[design/dfr_checker.sv]
// Port-level checker for the deframer, bound to the top level.
`default_nettype none

module dfr_checker import dfr_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  full_o,
  input wire logic                  empty_o,
  input wire logic                  pop_i,
  input wire logic [BYTE_W-1:0]     frame_length_o,
  input wire logic [BYTE_W-1:0]     data_byte_o,
  input wire logic [BYTE_W-1:0]     byte_index_o,
  input wire logic                  is_end_o,
  input wire logic                  checksum_ok_o
);

  // A waiting result beat stays in place until it is popped.
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(data_byte_o) && $stable(byte_index_o)
                              && $stable(is_end_o) && $stable(checksum_ok_o)))
    else $error("stalled result beat changed");

  // Payload beats never carry a checksum flag.
  a_ok_only_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !is_end_o) |-> !checksum_ok_o)
    else $error("checksum flag on a payload beat");

  // End beats carry zero data and zero index.
  a_end_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && is_end_o) |-> (data_byte_o == '0 && byte_index_o == '0))
    else $error("end beat with nonzero data or index");

  // A payload index always lies inside the declared length.
  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !is_end_o) |-> (byte_index_o < frame_length_o))
    else $error("payload index beyond frame length");

  // The queue can only fill up behind a result beat that is waiting on the output.
  a_full_behind_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !empty_o)
    else $error("input full while no result beat is offered");

endmodule : dfr_checker

bind sync_length_xor_deframer_top dfr_checker u_checker (.*);

`default_nettype wire

[tb/sv/sync_length_xor_deframer_top_tb.sv]
// Self-checking testbench for the sync/length/XOR frame deframer top level.
module sync_length_xor_deframer_top_tb import dfr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HALF_PERIOD = 10;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned RANDOM_ROUNDS = 8;
  localparam int unsigned BYTES_PER_ROUND = 175;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    POP_ALWAYS,
    POP_RANDOM,
    POP_EVERY_FOURTH,
    POP_SPARSE
  } pop_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [BYTE_W-1:0]     cfg_wdata_i = '0;
  logic                  push_i = 1'b0;
  logic [BYTE_W-1:0]     rx_byte_i = '0;
  logic                  pop_i = 1'b0;
  logic                  full_o;
  logic                  empty_o;
  logic [BYTE_W-1:0]     frame_id_o;
  logic [BYTE_W-1:0]     frame_length_o;
  logic [BYTE_W-1:0]     data_byte_o;
  logic [BYTE_W-1:0]     byte_index_o;
  logic                  is_end_o;
  logic                  checksum_ok_o;

  sync_length_xor_deframer_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push_i         (push_i),
    .full_o         (full_o),
    .rx_byte_i      (rx_byte_i),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .frame_id_o     (frame_id_o),
    .frame_length_o (frame_length_o),
    .data_byte_o    (data_byte_o),
    .byte_index_o   (byte_index_o),
    .is_end_o       (is_end_o),
    .checksum_ok_o  (checksum_ok_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Bytes waiting to be sent and items the parser is expected to produce.
  logic [BYTE_W-1:0] pending_bytes[$];
  dfr_item_t         expected_items[$];
  int unsigned       bytes_queued = 0;
  int unsigned       error_count = 0;

  // Shadow copy of the sync registers and of the frame parser.
  logic [BYTE_W-1:0] sync_first_q = '0;
  logic [BYTE_W-1:0] sync_second_q = '0;
  phase_e            parse_phase = PH_HUNT_FIRST;
  logic [BYTE_W-1:0] held_id = '0;
  logic [BYTE_W-1:0] held_length = '0;
  logic [BYTE_W-1:0] payload_count = '0;
  logic [BYTE_W-1:0] running_xor = '0;

  // Advance the parser by one received byte and record any item it yields.
  task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
    dfr_item_t item;
    item = '0;
    item.frame_id = held_id;
    item.frame_length = held_length;
    case (parse_phase)
      PH_HUNT_SECOND: begin
        if (b == sync_second_q) begin
          running_xor = sync_first_q ^ sync_second_q;
          parse_phase = PH_ID;
        end else if (b != sync_first_q) begin
          parse_phase = PH_HUNT_FIRST;
        end
      end
      PH_ID: begin
        held_id = b;
        running_xor ^= b;
        parse_phase = PH_LENGTH;
      end
      PH_LENGTH: begin
        held_length = b;
        running_xor ^= b;
        payload_count = '0;
        parse_phase = (b == '0) ? PH_CHECKSUM : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        item.data_byte = b;
        item.byte_index = payload_count;
        expected_items.push_back(item);
        running_xor ^= b;
        payload_count = payload_count + 1'b1;
        if (payload_count == held_length) begin
          parse_phase = PH_CHECKSUM;
        end
      end
      PH_CHECKSUM: begin
        item.is_end = 1'b1;
        item.checksum_ok = (b == running_xor);
        expected_items.push_back(item);
        parse_phase = PH_HUNT_FIRST;
      end
      default: begin
        parse_phase = (b == sync_first_q) ? PH_HUNT_SECOND : PH_HUNT_FIRST;
      end
    endcase
  endtask

  // Sender: bursts of beats separated by random gaps, holding each beat until taken.
  int unsigned burst_left = 20;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    logic accepted;
    accepted = push_i && !full_o;
    if (accepted) begin
      parse_rx_byte(rx_byte_i);
      void'(pending_bytes.pop_front());
      if (burst_left > 0) begin
        burst_left--;
      end
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          burst_left = $urandom_range(100, 300);
          gap_left = 0;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                                 : $urandom_range(0, 5);
        end
      end
    end
    if (!rst_ni) begin
      push_i <= 1'b0;
    end else if (push_i && !accepted) begin
      // The current beat stays on the port until it is taken.
    end else if (gap_left > 0) begin
      gap_left--;
      push_i <= 1'b0;
    end else if (pending_bytes.size() > 0) begin
      push_i <= 1'b1;
      rx_byte_i <= pending_bytes[0];
    end else begin
      push_i <= 1'b0;
    end
  end

  // Report one field that differs from its expected value.
  function automatic void check_field(input string name, input logic [BYTE_W-1:0] want,
                                      input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // Receiver: checks each popped beat and stalls on a changing pattern.
  pop_mode_e   pop_mode = POP_ALWAYS;
  int unsigned pop_mode_left = 100;
  int unsigned pop_tick = 0;

  always @(posedge clk_i) begin
    dfr_item_t want;
    if (!rst_ni) begin
      pop_i <= 1'b0;
    end else begin
      if (pop_i && !empty_o) begin
        if (expected_items.size() == 0) begin
          error_count++;
          $display("%0t: unexpected beat, expected none, got id %0h len %0h data %0h",
                   $time, frame_id_o, frame_length_o, data_byte_o);
        end else begin
          want = expected_items.pop_front();
          check_field("frame_id", want.frame_id, frame_id_o);
          check_field("frame_length", want.frame_length, frame_length_o);
          check_field("data_byte", want.data_byte, data_byte_o);
          check_field("byte_index", want.byte_index, byte_index_o);
          check_field("is_end", BYTE_W'(want.is_end), BYTE_W'(is_end_o));
          check_field("checksum_ok", BYTE_W'(want.checksum_ok), BYTE_W'(checksum_ok_o));
        end
      end
      if (pop_mode_left == 0) begin
        pop_mode = pop_mode_e'($urandom_range(0, 3));
        pop_mode_left = $urandom_range(32, 200);
      end else begin
        pop_mode_left--;
      end
      pop_tick++;
      case (pop_mode)
        POP_ALWAYS:       pop_i <= 1'b1;
        POP_RANDOM:       pop_i <= 1'($urandom_range(0, 1));
        POP_EVERY_FOURTH: pop_i <= (pop_tick % 4 == 0);
        default:          pop_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Write one sync register while the parser is idle; the task itself does not check this.
  task automatic write_reg(input cfg_reg_e idx, input logic [BYTE_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= value;
    if (idx == CFG_SYNC_FIRST) begin
      sync_first_q = value;
    end else begin
      sync_second_q = value;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_sync(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second);
    write_reg(CFG_SYNC_FIRST, first);
    write_reg(CFG_SYNC_SECOND, second);
  endtask

  task automatic queue_byte(input logic [BYTE_W-1:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  // Queue id, length, payload and checksum; seed is the XOR of the sync pair.
  task automatic queue_frame_body(input logic [BYTE_W-1:0] seed, input logic [BYTE_W-1:0] id,
                                  input logic [BYTE_W-1:0] len, input bit corrupt,
                                  input bit random_payload);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    sum = seed ^ id ^ len;
    queue_byte(id);
    queue_byte(len);
    for (int i = 0; i < len; i++) begin
      b = random_payload ? BYTE_W'($urandom) : (i[0] ? 8'hFF : 8'h00);
      sum ^= b;
      queue_byte(b);
    end
    if (corrupt) begin
      sum ^= BYTE_W'($urandom_range(1, 255));
    end
    queue_byte(sum);
  endtask

  task automatic queue_frame(input logic [BYTE_W-1:0] id, input logic [BYTE_W-1:0] len,
                             input bit corrupt, input bit random_payload);
    queue_byte(sync_first_q);
    queue_byte(sync_second_q);
    queue_frame_body(sync_first_q ^ sync_second_q, id, len, corrupt, random_payload);
  endtask

  // Wait until every byte is sent and every expected beat has arrived.
  task automatic wait_drained();
    while (pending_bytes.size() > 0 || push_i || expected_items.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Stimulus: directed frames first, then rounds of random traffic.
  initial begin
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] second;
    int unsigned round_start;
    int unsigned pick;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset sync values are equal: two zero bytes form a sync.
    queue_frame(8'h00, 8'h00, 1'b0, 1'b0);
    wait_drained();

    // Distinct sync values: a sliding hunt, a restart on a repeated first byte,
    // a mismatch that drops the hunt and a bad checksum.
    set_sync(8'hA5, 8'h5A);
    queue_byte(8'h5A);
    queue_byte(8'hA5);
    queue_frame(8'hFF, 8'h02, 1'b0, 1'b0);
    queue_byte(8'hA5);
    queue_byte(8'h13);
    queue_frame(8'h80, 8'h03, 1'b1, 1'b1);
    wait_drained();

    // Sync written mid-frame: the checksum keeps the old sync pair.
    queue_byte(8'hA5);
    queue_byte(8'h5A);
    wait_drained();
    set_sync(8'h3C, 8'hC3);
    queue_frame_body(8'hA5 ^ 8'h5A, 8'h7E, 8'h01, 1'b0, 1'b1);
    wait_drained();

    // Both sync values at the top of the range.
    set_sync(8'hFF, 8'hFF);
    queue_frame(8'h01, 8'h00, 1'b1, 1'b0);
    queue_frame(8'h00, 8'h01, 1'b0, 1'b0);
    wait_drained();

    // Random rounds, each with its own sync pair.
    for (int r = 0; r < RANDOM_ROUNDS; r++) begin
      first = BYTE_W'($urandom);
      case ($urandom_range(0, 3))
        0:       second = first;
        1:       second = 8'h00;
        2:       second = 8'hFF;
        default: second = BYTE_W'($urandom);
      endcase
      if (r == 0) begin
        first = 8'h00;
        second = 8'hFF;
      end
      set_sync(first, second);
      round_start = bytes_queued;
      while (bytes_queued - round_start < BYTES_PER_ROUND) begin
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
          pick = $urandom_range(0, 99);
          if (pick == 0) begin
            len = 8'hFF;
          end else if (pick < 4) begin
            len = BYTE_W'($urandom_range(17, 254));
          end else begin
            len = BYTE_W'($urandom_range(0, 15));
          end
          queue_frame(BYTE_W'($urandom), len, ($urandom_range(0, 3) == 0), 1'b1);
        end else if (pick < 86) begin
          repeat ($urandom_range(1, 4)) queue_byte(BYTE_W'($urandom));
        end else begin
          case ($urandom_range(0, 2))
            0: begin
              queue_byte(sync_first_q);
              queue_byte(BYTE_W'($urandom));
            end
            1: begin
              queue_byte(sync_first_q);
              queue_frame(BYTE_W'($urandom), BYTE_W'($urandom_range(0, 6)), 1'b0, 1'b1);
            end
            default: begin
              queue_byte(sync_first_q);
              queue_byte(sync_first_q ^ 8'h01);
            end
          endcase
        end
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("sync_length_xor_deframer_top verification clean");
    end else begin
      $display("sync_length_xor_deframer_top verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #8_000_000;
    $display("sync_length_xor_deframer_top verification failed");
    $finish;
  end

endmodule
